@@ design/vqcb_pkg.sv @@
// Shared types, constants and helper functions for the VQ codebook block decoder.
`timescale 1ns / 1ps

package vqcb_pkg;

    // Frame grid and store geometry
    localparam int GRID_COLUMNS     = 60;
    localparam int MAX_GRID_ROWS    = 128;
    localparam int CODEBOOK_ENTRIES = 256;
    localparam int LUMA_DEPTH       = 4096;
    localparam int CHROMA_DEPTH     = 2048;
    localparam int LUMA_AW          = $clog2(LUMA_DEPTH);
    localparam int CHROMA_AW        = $clog2(CHROMA_DEPTH);
    localparam int POS_W            = 13;
    localparam int COL_W            = 6;
    localparam int ROW_W            = 7;

    // Request command codes
    localparam logic CMD_CODEBOOK = 1'b0;
    localparam logic CMD_INDEX    = 1'b1;

    // Configuration register indexes
    localparam logic REG_BLOCK_MODE  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    // Reset values of the configuration registers
    localparam logic [2:0] BLOCK_MODE_RST  = 3'd0;
    localparam logic [7:0] GRID_HEIGHT_RST = 8'd40;

    // Block sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_seq_state;

    // Per-pixel tag that travels alongside the store reads
    typedef struct packed {
        logic [7:0] x;
        logic [8:0] y;
        logic       last_blk;
        logic       last_frm;
    } t_pix_tag;

    // Block width from mode: 4x4, 4x3, 3x3, 4x2
    function automatic logic [2:0] block_width(input logic [2:0] mode);
        logic [2:0] w;
        unique case (mode[2:1])
            2'd2:    w = 3'd3;
            default: w = 3'd4;
        endcase
        return w;
    endfunction

    // Block height from mode
    function automatic logic [2:0] block_height(input logic [2:0] mode);
        logic [2:0] h;
        unique case (mode[2:1])
            2'd0:    h = 3'd4;
            2'd1:    h = 3'd3;
            2'd2:    h = 3'd3;
            default: h = 3'd2;
        endcase
        return h;
    endfunction

    // Chroma pairs per block: one per row for odd modes, else one
    function automatic logic [2:0] chroma_pairs(input logic [2:0] mode);
        return mode[0] ? block_height(mode) : 3'd1;
    endfunction

    // Saturate a signed sum to an unsigned byte
    function automatic logic [7:0] clip8(input logic signed [10:0] v);
        logic [7:0] r;
        if (v < 0) begin
            r = 8'd0;
        end else if (v > 11'sd255) begin
            r = 8'd255;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

@@ design/vqcb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module vqcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ design/vqcb_color_conv.sv @@
// YCbCr to clipped RGB converter with the registered pixel output stage.
`timescale 1ns / 1ps

module vqcb_color_conv import vqcb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_pix_tag   i_tag,
    input  logic [7:0] i_luma,
    input  logic [7:0] i_cb,
    input  logic [7:0] i_cr,
    output logic       o_valid,
    output t_pix_tag   o_tag,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);

    logic signed [10:0] y_s;
    logic signed [10:0] cb_s;
    logic signed [10:0] cr_s;
    logic signed [10:0] cb_half;
    logic signed [10:0] red_sum;
    logic signed [10:0] green_sum;
    logic signed [10:0] blue_sum;

    // Chroma is signed; Cb halves by arithmetic shift (rounds down)
    always_comb begin
        y_s       = $signed({3'b000, i_luma});
        cb_s      = $signed({{3{i_cb[7]}}, i_cb});
        cr_s      = $signed({{3{i_cr[7]}}, i_cr});
        cb_half   = $signed({{4{i_cb[7]}}, i_cb[7:1]});
        red_sum   = y_s + (cr_s <<< 1);
        green_sum = y_s - cr_s - cb_half;
        blue_sum  = y_s + (cb_s <<< 1);
    end

    // Strobe register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    // Pixel payload registers
    always_ff @(posedge i_clk) begin
        o_tag   <= i_tag;
        o_red   <= clip8(red_sum);
        o_green <= clip8(green_sum);
        o_blue  <= clip8(blue_sum);
    end

endmodule

@@ design/vq_codebook_block_decoder.sv @@
// Top level: codebook loader, block sequencer and pixel output of the VQ block decoder.
//
//  channel   | ports                                         | handshake
//  ----------+-----------------------------------------------+------------------------------
//  request   | i_command, i_data_byte, i_restart             | i_start high, o_busy low
//  config    | i_cfg_idx, i_cfg_wdata                        | i_cfg_we high, no wait
//  pixel     | o_red/green/blue, o_pixel_x/y, o_last_of_*    | o_valid for one cycle
//
//  A codebook byte is written in the cycle it is accepted; o_busy stays low.
//  A block index holds o_busy after acceptance until all W*H pixels (16 for 4x4) are
//  issued; the luma store read port delivers one pixel a cycle. Pixels leave through
//  the tag stage and output register after their store read, one per cycle, in block order.
//  Reset is synchronous active low; the stores are not cleared.
//  The receiver cannot stall: o_valid pulses are taken as they come.
`timescale 1ns / 1ps

module vq_codebook_block_decoder import vqcb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic       i_command,
    input  logic [7:0] i_data_byte,
    input  logic       i_restart,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    output logic       o_valid,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic [7:0] o_pixel_x,
    output logic [8:0] o_pixel_y,
    output logic       o_last_of_block,
    output logic       o_last_of_frame
);

    // Configuration
    logic [2:0] r_block_mode;
    logic [7:0] r_grid_height;

    // Loader state
    logic [POS_W-1:0] r_load_pos, n_load_pos;
    logic [7:0]       r_sum, n_sum;

    // Grid position
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    // Sequencer state
    t_seq_state           r_state, n_state;
    logic [1:0]           r_i, n_i;
    logic [1:0]           r_j, n_j;
    logic [2:0]           r_bw, n_bw;
    logic [2:0]           r_bh, n_bh;
    logic                 r_per_row, n_per_row;
    logic [LUMA_AW-1:0]   r_luma_addr, n_luma_addr;
    logic [CHROMA_AW-1:0] r_cb_addr, n_cb_addr;
    logic [CHROMA_AW-1:0] r_cr_off, n_cr_off;
    logic [7:0]           r_base_x, n_base_x;
    logic [8:0]           r_base_y, n_base_y;
    logic                 r_end_frame, n_end_frame;

    // Read pipeline stage
    logic     r_p1_valid;
    t_pix_tag r_p1_tag;
    t_pix_tag issue_tag;
    logic     issue;

    // Store ports
    logic                 luma_we, chroma_we;
    logic [LUMA_AW-1:0]   luma_waddr;
    logic [CHROMA_AW-1:0] chroma_waddr;
    logic [LUMA_AW-1:0]   luma_raddr;
    logic [CHROMA_AW-1:0] cb_raddr, cr_raddr;
    logic [7:0]           luma_rdata, cb_rdata, cr_rdata;

    // Mode decode for the current configuration
    logic [2:0]       cur_bw, cur_bh, cur_crows;
    logic [4:0]       cur_area;
    logic [POS_W-1:0] luma_len, total_len;

    // Request decode
    logic accept, acc_cb, acc_idx;
    logic [POS_W-1:0] load_p;
    logic [7:0]       sum_base;
    logic [POS_W-1:0] chroma_off;

    // Grid decode
    logic [7:0] rows_eff;
    logic       end_row, end_frame;
    logic       last_col, last_row_px;

    t_pix_tag conv_tag;

    assign o_busy  = (r_state == ST_RUN);
    assign accept  = i_start && !o_busy;
    assign acc_cb  = accept && (i_command == CMD_CODEBOOK);
    assign acc_idx = accept && (i_command == CMD_INDEX);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_mode  <= BLOCK_MODE_RST;
            r_grid_height <= GRID_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BLOCK_MODE:  r_block_mode  <= i_cfg_wdata[2:0];
                REG_GRID_HEIGHT: r_grid_height <= i_cfg_wdata;
                default:         r_block_mode  <= r_block_mode;
            endcase
        end
    end

    // Region lengths for the current mode
    always_comb begin
        cur_bw    = block_width(r_block_mode);
        cur_bh    = block_height(r_block_mode);
        cur_crows = chroma_pairs(r_block_mode);
        cur_area  = 5'(cur_bw * cur_bh);
        luma_len  = {cur_area, 8'd0};
        total_len = luma_len + {1'b0, cur_crows, 9'd0};
    end

    // Codebook loader: running sum restarts at each region start
    always_comb begin
        load_p       = i_restart ? '0 : r_load_pos;
        sum_base     = (i_restart || load_p == '0 || load_p == luma_len) ? 8'd0 : r_sum;
        chroma_off   = load_p - luma_len;
        luma_waddr   = load_p[LUMA_AW-1:0];
        chroma_waddr = chroma_off[CHROMA_AW-1:0];
        luma_we      = 1'b0;
        chroma_we    = 1'b0;
        n_load_pos   = r_load_pos;
        n_sum        = r_sum;
        if (acc_cb) begin
            n_load_pos = load_p;
            n_sum      = i_restart ? 8'd0 : r_sum;
            if (load_p < total_len) begin
                n_sum      = sum_base + i_data_byte;
                n_load_pos = load_p + 1'b1;
                luma_we    = (load_p < luma_len);
                chroma_we  = !(load_p < luma_len);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos <= '0;
            r_sum      <= '0;
        end else begin
            r_load_pos <= n_load_pos;
            r_sum      <= n_sum;
        end
    end

    // Grid height clamp and frame-end decode
    always_comb begin
        if (r_grid_height == 8'd0) begin
            rows_eff = 8'd1;
        end else if (r_grid_height > 8'(MAX_GRID_ROWS)) begin
            rows_eff = 8'(MAX_GRID_ROWS);
        end else begin
            rows_eff = r_grid_height;
        end
        end_row   = ({1'b0, r_col} + 1'b1) >= 7'(GRID_COLUMNS);
        end_frame = end_row && (({1'b0, r_row} + 1'b1) >= rows_eff);
    end

    // Sequencer: next state, counters and address generation
    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_bw        = r_bw;
        n_bh        = r_bh;
        n_per_row   = r_per_row;
        n_luma_addr = r_luma_addr;
        n_cb_addr   = r_cb_addr;
        n_cr_off    = r_cr_off;
        n_base_x    = r_base_x;
        n_base_y    = r_base_y;
        n_end_frame = r_end_frame;
        n_col       = r_col;
        n_row       = r_row;
        last_col    = ({1'b0, r_i} + 1'b1) == r_bw;
        last_row_px = ({1'b0, r_j} + 1'b1) == r_bh;
        issue       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (acc_idx) begin
                    n_state     = ST_RUN;
                    n_i         = 2'd0;
                    n_j         = 2'd0;
                    n_bw        = cur_bw;
                    n_bh        = cur_bh;
                    n_per_row   = r_block_mode[0];
                    n_luma_addr = LUMA_AW'(i_data_byte * cur_area);
                    n_cb_addr   = CHROMA_AW'(i_data_byte * cur_crows);
                    n_cr_off    = {cur_crows, 8'd0};
                    n_base_x    = 8'(r_col * cur_bw);
                    n_base_y    = 9'(r_row * cur_bh);
                    n_end_frame = end_frame;
                    if (end_row) begin
                        n_col = '0;
                        n_row = end_frame ? '0 : r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            ST_RUN: begin
                issue       = 1'b1;
                n_luma_addr = r_luma_addr + 1'b1;
                if (last_col) begin
                    n_i = 2'd0;
                    n_j = r_j + 1'b1;
                    if (r_per_row) begin
                        n_cb_addr = r_cb_addr + 1'b1;
                    end
                    if (last_row_px) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bw        <= n_bw;
        r_bh        <= n_bh;
        r_per_row   <= n_per_row;
        r_luma_addr <= n_luma_addr;
        r_cb_addr   <= n_cb_addr;
        r_cr_off    <= n_cr_off;
        r_base_x    <= n_base_x;
        r_base_y    <= n_base_y;
        r_end_frame <= n_end_frame;
    end

    // Read addresses and tag of the pixel being issued
    always_comb begin
        luma_raddr         = r_luma_addr;
        cb_raddr           = r_cb_addr;
        cr_raddr           = r_cb_addr + r_cr_off;
        issue_tag.x        = r_base_x + {6'd0, r_i};
        issue_tag.y        = r_base_y + {7'd0, r_j};
        issue_tag.last_blk = last_col && last_row_px;
        issue_tag.last_frm = last_col && last_row_px && r_end_frame;
    end

    // Tag stage, aligned with the registered store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else begin
            r_p1_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_tag <= issue_tag;
    end

    // Stores: Cb and Cr read from two identical chroma copies
    vqcb_ram #(.WIDTH(8), .DEPTH(LUMA_DEPTH)) u_luma_ram (
        .i_clk   (i_clk),
        .i_we    (luma_we),
        .i_waddr (luma_waddr),
        .i_wdata (n_sum),
        .i_raddr (luma_raddr),
        .o_rdata (luma_rdata)
    );

    vqcb_ram #(.WIDTH(8), .DEPTH(CHROMA_DEPTH)) u_cb_ram (
        .i_clk   (i_clk),
        .i_we    (chroma_we),
        .i_waddr (chroma_waddr),
        .i_wdata (n_sum),
        .i_raddr (cb_raddr),
        .o_rdata (cb_rdata)
    );

    vqcb_ram #(.WIDTH(8), .DEPTH(CHROMA_DEPTH)) u_cr_ram (
        .i_clk   (i_clk),
        .i_we    (chroma_we),
        .i_waddr (chroma_waddr),
        .i_wdata (n_sum),
        .i_raddr (cr_raddr),
        .o_rdata (cr_rdata)
    );

    // Color conversion and output register
    vqcb_color_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p1_valid),
        .i_tag   (r_p1_tag),
        .i_luma  (luma_rdata),
        .i_cb    (cb_rdata),
        .i_cr    (cr_rdata),
        .o_valid (o_valid),
        .o_tag   (conv_tag),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

    assign o_pixel_x       = conv_tag.x;
    assign o_pixel_y       = conv_tag.y;
    assign o_last_of_block = conv_tag.last_blk;
    assign o_last_of_frame = conv_tag.last_frm;

`ifndef SYNTHESIS
    // Block index request starts the sequencer
    a_idx_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_idx |=> o_busy)
        else $error("index request did not start the sequencer");

    // Codebook byte completes in the cycle it is taken
    a_cb_nobusy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_cb |=> !o_busy)
        else $error("codebook byte left the block busy");

    // Load position never runs past both regions
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_pos <= 13'd6144)
        else $error("load position out of range");

    // Frame end only on a block end
    a_lof_lob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_frame) |-> o_last_of_block)
        else $error("frame end without block end");

    // Pixel strobe follows an issue through the tag stage and the output register
    a_out_lag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |=> ##1 o_valid)
        else $error("pixel strobe missing after store read");
`endif

endmodule

@@ tb/tb_vq_codebook_block_decoder.sv @@
// Self-checking testbench for the VQ codebook block decoder: queued requests, pixel scoreboard.
`timescale 1ns / 1ps

module tb_vq_codebook_block_decoder import vqcb_pkg::*; ();

    // Cycles to let the pipeline empty once the pixel queue is empty.
    localparam int SETTLE_CYCLES = 24;
    // About 18k requests, each at worst its longest idle gap plus a busy block, with margin.
    localparam int LIMIT_CYCLES  = 2_000_000;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        logic       restart;
        logic [4:0] gap;
    } t_request;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] x;
        logic [8:0] y;
        logic       last_blk;
        logic       last_frm;
    } t_pixel;

    // DUT ports
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_start     = 1'b0;
    logic       i_command   = CMD_CODEBOOK;
    logic [7:0] i_data_byte = 8'd0;
    logic       i_restart   = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_idx   = REG_BLOCK_MODE;
    logic [7:0] i_cfg_wdata = 8'd0;
    logic       o_busy;
    logic       o_valid;
    logic [7:0] o_red;
    logic [7:0] o_green;
    logic [7:0] o_blue;
    logic [7:0] o_pixel_x;
    logic [8:0] o_pixel_y;
    logic       o_last_of_block;
    logic       o_last_of_frame;

    vq_codebook_block_decoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_command       (i_command),
        .i_data_byte     (i_data_byte),
        .i_restart       (i_restart),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_valid         (o_valid),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_last_of_block (o_last_of_block),
        .o_last_of_frame (o_last_of_frame)
    );

    t_request pending_reqs[$];
    t_pixel   expected_pixels[$];
    int       err_count   = 0;
    int       cycle_count = 0;
    int       idle_cycles = 0;
    bit       calm        = 1'b0;
    bit       req_taken   = 1'b0;

    // Decoder shadow state
    logic [7:0] luma_mem   [LUMA_DEPTH];
    logic [7:0] chroma_mem [CHROMA_DEPTH];
    int         load_pos   = 0;
    logic [7:0] delta_sum  = 8'd0;
    int         blk_col    = 0;
    int         blk_row    = 0;
    logic [2:0] cur_mode   = BLOCK_MODE_RST;
    logic [7:0] cur_height = GRID_HEIGHT_RST;

    // Block geometry: 4x4, 4x3, 3x3, 4x2 by mode pair
    function automatic int blk_w(logic [2:0] mode);
        return (mode[2:1] == 2'd2) ? 3 : 4;
    endfunction

    function automatic int blk_h(logic [2:0] mode);
        int h;
        case (mode[2:1])
            2'd0:    h = 4;
            2'd3:    h = 2;
            default: h = 3;
        endcase
        return h;
    endfunction

    function automatic int chroma_per_blk(logic [2:0] mode);
        return mode[0] ? blk_h(mode) : 1;
    endfunction

    function automatic int codebook_bytes(logic [2:0] mode);
        return CODEBOOK_ENTRIES * blk_w(mode) * blk_h(mode)
               + 2 * CODEBOOK_ENTRIES * chroma_per_blk(mode);
    endfunction

    function automatic logic [7:0] sat_byte(int v);
        logic [7:0] r;
        if (v < 0) begin
            r = 8'd0;
        end else if (v > 255) begin
            r = 8'd255;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

    function automatic int as_signed_byte(logic [7:0] b);
        return b[7] ? int'(b) - 256 : int'(b);
    endfunction

    // Shadow decoder: update the store on a codebook byte, queue pixels on an index
    function automatic void decode_request(logic cmd, logic [7:0] data, logic restart);
        int     bw, bh, crows, luma_len, total, rows, e, k, cb, cr, luma, i, j;
        bit     end_row, end_frame, last;
        t_pixel px;
        bw       = blk_w(cur_mode);
        bh       = blk_h(cur_mode);
        crows    = chroma_per_blk(cur_mode);
        luma_len = CODEBOOK_ENTRIES * bw * bh;
        total    = luma_len + 2 * CODEBOOK_ENTRIES * crows;
        if (cmd == CMD_CODEBOOK) begin
            if (restart) begin
                load_pos  = 0;
                delta_sum = 8'd0;
            end
            // bytes past the end of both regions are dropped
            if (load_pos < total) begin
                if (load_pos == 0 || load_pos == luma_len) begin
                    delta_sum = 8'd0;
                end
                delta_sum = delta_sum + data;
                if (load_pos < luma_len) begin
                    luma_mem[load_pos % LUMA_DEPTH] = delta_sum;
                end else begin
                    chroma_mem[(load_pos - luma_len) % CHROMA_DEPTH] = delta_sum;
                end
                load_pos++;
            end
        end else begin
            rows = (cur_height == 8'd0) ? 1 :
                   (int'(cur_height) > MAX_GRID_ROWS) ? MAX_GRID_ROWS : int'(cur_height);
            e         = int'(data);
            end_row   = (blk_col + 1 >= GRID_COLUMNS);
            end_frame = end_row && (blk_row + 1 >= rows);
            for (j = 0; j < bh; j++) begin
                k  = e * crows + ((crows == 1) ? 0 : j);
                cb = as_signed_byte(chroma_mem[k % CHROMA_DEPTH]);
                cr = as_signed_byte(chroma_mem[(CODEBOOK_ENTRIES * crows + k) % CHROMA_DEPTH]);
                for (i = 0; i < bw; i++) begin
                    luma        = int'(luma_mem[(e * bw * bh + j * bw + i) % LUMA_DEPTH]);
                    last        = (j == bh - 1) && (i == bw - 1);
                    px.red      = sat_byte(luma + 2 * cr);
                    px.green    = sat_byte(luma - cr - (cb >>> 1));
                    px.blue     = sat_byte(luma + 2 * cb);
                    px.x        = 8'(blk_col * bw + i);
                    px.y        = 9'(blk_row * bh + j);
                    px.last_blk = last;
                    px.last_frm = last && end_frame;
                    expected_pixels.push_back(px);
                end
            end
            if (end_row) begin
                blk_col = 0;
                blk_row = end_frame ? 0 : ((blk_row + 1) % 128);
            end else begin
                blk_col = (blk_col + 1) % 64;
            end
        end
    endfunction

    // Compare one output pixel with the oldest expectation
    function automatic void check_pixel();
        t_pixel got, want;
        got = {o_red, o_green, o_blue, o_pixel_x, o_pixel_y, o_last_of_block, o_last_of_frame};
        if (expected_pixels.size() == 0) begin
            err_count++;
            $display("%0t: unexpected pixel, expected none, got rgb=%02x/%02x/%02x xy=%0d,%0d",
                     $time, got.red, got.green, got.blue, got.x, got.y);
        end else begin
            want = expected_pixels.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
                got.x !== want.x || got.y !== want.y || got.last_blk !== want.last_blk ||
                got.last_frm !== want.last_frm) begin
                err_count++;
                $display("%0t: pixel mismatch expected rgb=%02x/%02x/%02x xy=%0d,%0d lb=%0b lf=%0b",
                         $time, want.red, want.green, want.blue, want.x, want.y,
                         want.last_blk, want.last_frm);
                $display("%0t:                actual   rgb=%02x/%02x/%02x xy=%0d,%0d lb=%0b lf=%0b",
                         $time, got.red, got.green, got.blue, got.x, got.y,
                         got.last_blk, got.last_frm);
            end
        end
    endfunction

    // Clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d pixels outstanding", $time, expected_pixels.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Monitor: register writes, accepted requests and output pixels at the rising edge
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && i_start && !o_busy;
        if (i_rst_n) begin
            if (o_valid) begin
                check_pixel();
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_BLOCK_MODE) begin
                    cur_mode = i_cfg_wdata[2:0];
                end else begin
                    cur_height = i_cfg_wdata;
                end
            end
            if (i_start && !o_busy) begin
                decode_request(i_command, i_data_byte, i_restart);
            end
        end
    end

    // Driver: present the queue head at the falling edge, honoring its idle gap
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start     <= 1'b0;
            idle_cycles = 0;
        end else if (!(i_start && !req_taken)) begin
            if (req_taken) begin
                pending_reqs.delete(0);
                idle_cycles = 0;
            end
            if (pending_reqs.size() != 0 && idle_cycles >= int'(pending_reqs[0].gap)) begin
                i_start     <= 1'b1;
                i_command   <= pending_reqs[0].cmd;
                i_data_byte <= pending_reqs[0].data;
                i_restart   <= pending_reqs[0].restart;
            end else begin
                i_start <= 1'b0;
                if (pending_reqs.size() != 0) begin
                    idle_cycles++;
                end
            end
        end
    end

    // Queue one request; bulk loads mostly run back to back
    task automatic queue_req(input logic cmd, input logic [7:0] data, input logic restart,
                             input bit bulk);
        t_request r;
        r.cmd     = cmd;
        r.data    = data;
        r.restart = restart;
        if (bulk) begin
            r.gap = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(0, 19)) : 5'd0;
        end else begin
            if ($urandom_range(0, 15) == 0) begin
                calm = !calm;
            end
            r.gap = calm ? 5'd0 : 5'($urandom_range(0, 19));
        end
        pending_reqs.push_back(r);
    endtask

    // Whole codebook for a mode, starting with a restart, plus surplus bytes
    task automatic queue_codebook(input int len, input int surplus);
        int n;
        queue_req(CMD_CODEBOOK, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
        for (n = 1; n < len + surplus; n++) begin
            queue_req(CMD_CODEBOOK, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    // Mostly lookups with random entries; some codebook bytes, rare restarts
    task automatic queue_mixed(input int count, input int byte_pct);
        int n;
        for (n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < byte_pct) begin
                queue_req(CMD_CODEBOOK, 8'($urandom_range(0, 255)),
                          ($urandom_range(0, 7) == 0), 1'b0);
            end else begin
                queue_req(CMD_INDEX, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
            end
        end
    endtask

    // Wait until the queue is drained and every pixel is in, then let the pipeline empty
    task automatic settle();
        while (pending_reqs.size() != 0 || i_start || expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Stimulus
    initial begin
        int n, m;
        int heights[6];
        heights = '{128, 255, 7, 1, 40, 3};
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: a stray partial load, then a full one that restarts over it
        for (n = 0; n < 20; n++) begin
            queue_req(CMD_CODEBOOK, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
        queue_codebook(codebook_bytes(BLOCK_MODE_RST), 5);
        queue_req(CMD_INDEX, 8'd0, 1'b0, 1'b0);
        queue_req(CMD_INDEX, 8'd255, 1'b0, 1'b0);
        queue_req(CMD_INDEX, 8'd128, 1'b1, 1'b0);
        queue_req(CMD_INDEX, 8'd1, 1'b1, 1'b0);
        queue_mixed(4, 0);
        settle();

        // 4x4 with per-row chroma fills both stores completely; zero height acts as one row
        write_reg(REG_BLOCK_MODE, 8'd1);
        write_reg(REG_GRID_HEIGHT, 8'd0);
        queue_codebook(codebook_bytes(3'd1), 3);
        queue_mixed(65, 5);
        settle();

        // Every other mode, with reloads in two of them and mode changes over stale data
        for (m = 2; m <= 7; m++) begin
            write_reg(REG_BLOCK_MODE, 8'(m));
            write_reg(REG_GRID_HEIGHT, 8'(heights[m - 2]));
            if (m == 5 || m == 6) begin
                queue_codebook(codebook_bytes(3'(m)), 2);
            end
            queue_mixed(18, 20);
            settle();
        end

        // Lower the height below the current block row: the current row then ends the frame
        write_reg(REG_BLOCK_MODE, 8'd0);
        write_reg(REG_GRID_HEIGHT, 8'd40);
        queue_mixed(62, 0);
        settle();
        write_reg(REG_GRID_HEIGHT, 8'd1);
        queue_mixed(60, 0);
        settle();

        if (err_count == 0 && expected_pixels.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
